@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define DEQ_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DEQ_ASSERT_ALWAYS(label, cond, msg)

`define DEQ_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ rtl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// shared constants, operation codes and cell control types of the deque
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

    localparam int DEPTH  = 64;
    localparam int WORD_W = 32;
    localparam int KIND_W = 3;
    localparam int STAT_W = 2;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_PEEK_FRONT = 3'd4,
        KIND_PEEK_BACK  = 3'd5,
        KIND_CLEAR      = 3'd6
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD        = 3'd0,
        CELL_SHIFT_RIGHT = 3'd1,
        CELL_SHIFT_LEFT  = 3'd2,
        CELL_PUSH_TAIL   = 3'd3,
        CELL_DROP_TAIL   = 3'd4,
        CELL_CLEAR       = 3'd5
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t                 cmd;
        logic signed [WORD_W-1:0]  value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/deq_if.sv @@
// ----------------------------------------------------------------------------
// deq_if
// valid/ready channels for deque requests and responses
// ----------------------------------------------------------------------------
`default_nettype none

interface deq_req_if;
    logic                                valid;
    logic                                ready;
    logic [deq_pkg::KIND_W-1:0]          kind;
    logic signed [deq_pkg::WORD_W-1:0]   value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface deq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [deq_pkg::WORD_W-1:0]   read_value;
    logic [deq_pkg::CNT_W-1:0]           count;
    logic [deq_pkg::STAT_W-1:0]          status;

    modport source (output valid, output read_value, output count, output status,
                    input ready);
    modport sink   (input valid, input read_value, input count, input status,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/deq_cell.sv @@
// ----------------------------------------------------------------------------
// deq_cell
// one slot of the deque chain: a word and its occupancy, shifting to either
// neighbor or taking a pushed word at the tail
// ----------------------------------------------------------------------------
`default_nettype none

module deq_cell (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire deq_pkg::cell_ctrl_t               ctrl,
    input  wire logic                              prev_valid,
    input  wire logic signed [deq_pkg::WORD_W-1:0] prev_data,
    input  wire logic                              next_valid,
    input  wire logic signed [deq_pkg::WORD_W-1:0] next_data,
    output logic                                   valid,
    output logic signed [deq_pkg::WORD_W-1:0]      data,
    output logic signed [deq_pkg::WORD_W-1:0]      tail_data
);

    logic                              valid_reg;
    logic                              valid_next;
    logic signed [deq_pkg::WORD_W-1:0] data_reg;
    logic signed [deq_pkg::WORD_W-1:0] data_next;
    logic                              is_tail;
    logic                              is_free_head;

    assign is_tail      = valid_reg && !next_valid;
    assign is_free_head = !valid_reg && prev_valid;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        unique case (ctrl.cmd)
            deq_pkg::CELL_HOLD:
            begin
                valid_next = valid_reg;
            end
            deq_pkg::CELL_SHIFT_RIGHT:
            begin
                valid_next = prev_valid;
                data_next  = prev_data;
            end
            deq_pkg::CELL_SHIFT_LEFT:
            begin
                valid_next = next_valid;
                data_next  = next_data;
            end
            deq_pkg::CELL_PUSH_TAIL:
            begin
                if (is_free_head)
                begin
                    valid_next = 1'b1;
                    data_next  = ctrl.value;
                end
            end
            deq_pkg::CELL_DROP_TAIL:
            begin
                if (is_tail)
                begin
                    valid_next = 1'b0;
                end
            end
            deq_pkg::CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid     = valid_reg;
    assign data      = data_reg;
    assign tail_data = is_tail ? data_reg : '0;

endmodule

`default_nettype wire

@@ rtl/double_ended_queue_unit.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Deque of signed 32-bit words held in a chain of DEPTH cells, front in cell
// zero. Each request transfer (push front/back, pop front/back, peek
// front/back, clear) yields one response transfer with the word read, the
// count after the operation and a status. A request is taken in every cycle
// the response register is free or being drained, so the unit sustains one
// operation per clock; the response is registered and appears in the cycle
// after its request. Push front and pop front move every cell one place
// together; the back word is picked by the cell that sees an empty neighbor.
// No clearing pass after reset: the unit takes requests at once.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module double_ended_queue_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    deq_req_if.sink    req,
    deq_rsp_if.source  rsp
);

    localparam int N = deq_pkg::DEPTH;

    deq_pkg::cell_ctrl_t               cell_ctrl;
    logic [N-1:0]                      valid_vec;
    logic signed [deq_pkg::WORD_W-1:0] data_vec [N];
    logic signed [deq_pkg::WORD_W-1:0] tail_vec [N];
    logic signed [deq_pkg::WORD_W-1:0] back_data;
    logic signed [deq_pkg::WORD_W-1:0] front_data;

    logic [deq_pkg::CNT_W-1:0]         held_reg;
    logic [deq_pkg::CNT_W-1:0]         held_next;
    logic                              rsp_valid_reg;
    logic                              rsp_valid_next;
    logic signed [deq_pkg::WORD_W-1:0] read_value_reg;
    logic signed [deq_pkg::WORD_W-1:0] read_value_next;
    logic [deq_pkg::CNT_W-1:0]         count_reg;
    deq_pkg::status_t                  status_reg;
    deq_pkg::status_t                  status_next;

    logic                              fire;
    logic                              is_full;
    logic                              is_empty;
    deq_pkg::kind_t                    kind;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;
    assign kind      = deq_pkg::kind_t'(req.kind);
    assign is_full   = (held_reg == deq_pkg::CNT_W'(N));
    assign is_empty  = (held_reg == '0);

    // cell chain
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic                              p_valid;
        logic signed [deq_pkg::WORD_W-1:0] p_data;
        logic                              n_valid;
        logic signed [deq_pkg::WORD_W-1:0] n_data;

        if (i == 0)
        begin : g_first
            assign p_valid = 1'b1;
            assign p_data  = req.value;
        end
        else
        begin : g_mid
            assign p_valid = valid_vec[i-1];
            assign p_data  = data_vec[i-1];
        end

        if (i == N - 1)
        begin : g_last
            assign n_valid = 1'b0;
            assign n_data  = '0;
        end
        else
        begin : g_inner
            assign n_valid = valid_vec[i+1];
            assign n_data  = data_vec[i+1];
        end

        deq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl),
            .prev_valid (p_valid),
            .prev_data  (p_data),
            .next_valid (n_valid),
            .next_data  (n_data),
            .valid      (valid_vec[i]),
            .data       (data_vec[i]),
            .tail_data  (tail_vec[i])
        );
    end

    assign front_data = data_vec[0];

    // only the tail cell can drive a nonzero word
    always_comb
    begin
        back_data = '0;
        for (int i = 0; i < N; i++)
        begin
            back_data = back_data | tail_vec[i];
        end
    end

    // operation decode
    always_comb
    begin
        cell_ctrl.cmd   = deq_pkg::CELL_HOLD;
        cell_ctrl.value = req.value;
        held_next       = held_reg;
        read_value_next = '0;
        status_next     = deq_pkg::ST_OK;
        if (fire)
        begin
            unique case (kind)
                deq_pkg::KIND_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = deq_pkg::ST_FULL;
                    end
                    else
                    begin
                        cell_ctrl.cmd = deq_pkg::CELL_SHIFT_RIGHT;
                        held_next     = held_reg + 1'b1;
                    end
                end
                deq_pkg::KIND_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = deq_pkg::ST_FULL;
                    end
                    else
                    begin
                        cell_ctrl.cmd = deq_pkg::CELL_PUSH_TAIL;
                        held_next     = held_reg + 1'b1;
                    end
                end
                deq_pkg::KIND_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = deq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        read_value_next = front_data;
                        cell_ctrl.cmd   = deq_pkg::CELL_SHIFT_LEFT;
                        held_next       = held_reg - 1'b1;
                    end
                end
                deq_pkg::KIND_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        status_next = deq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        read_value_next = back_data;
                        cell_ctrl.cmd   = deq_pkg::CELL_DROP_TAIL;
                        held_next       = held_reg - 1'b1;
                    end
                end
                deq_pkg::KIND_PEEK_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = deq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        read_value_next = front_data;
                    end
                end
                deq_pkg::KIND_PEEK_BACK:
                begin
                    if (is_empty)
                    begin
                        status_next = deq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        read_value_next = back_data;
                    end
                end
                deq_pkg::KIND_CLEAR:
                begin
                    cell_ctrl.cmd = deq_pkg::CELL_CLEAR;
                    held_next     = '0;
                end
                default:
                begin
                    held_next = held_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg      <= held_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            read_value_reg <= read_value_next;
            count_reg      <= held_next;
            status_reg     <= status_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_value = read_value_reg;
    assign rsp.count      = count_reg;
    assign rsp.status     = status_reg;

    // checks
    `DEQ_ASSERT_ALWAYS(a_held_matches_cells, held_reg == deq_pkg::CNT_W'($countones(valid_vec)), "count disagrees with occupied cells")
    `DEQ_ASSERT_ALWAYS(a_front_cell_valid, valid_vec[0] == (held_reg != '0), "front cell occupancy wrong")
    `DEQ_ASSERT_NEXT(a_full_push_holds, fire && is_full && (kind == deq_pkg::KIND_PUSH_FRONT || kind == deq_pkg::KIND_PUSH_BACK), held_reg == deq_pkg::CNT_W'(N) && status_reg == deq_pkg::ST_FULL, "push into full deque changed state")
    `DEQ_ASSERT_NEXT(a_pop_ok, fire && !is_empty && (kind == deq_pkg::KIND_POP_FRONT || kind == deq_pkg::KIND_POP_BACK), status_reg == deq_pkg::ST_OK && held_reg == $past(held_reg) - 1'b1, "pop of nonempty deque failed")

endmodule

`default_nettype wire
